@@ sv/adaptive_refresh_scan_pacer_core_defines.svh @@
// Assertion macros shared by the pacer RTL.
`ifndef ADAPTIVE_REFRESH_SCAN_PACER_CORE_DEFINES_SVH
`define ADAPTIVE_REFRESH_SCAN_PACER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define ARSP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("arsp: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define ARSP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("arsp: next-cycle check failed");

`endif

@@ sv/arsp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package arsp_pkg;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  typedef logic [1:0] kind_t;
  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

  localparam kind_t KIND_TICK = 2'd0;
  localparam kind_t KIND_SERVICE = 2'd1;
  localparam kind_t KIND_SCAN_DONE = 2'd2;
  localparam kind_t KIND_RESTART = 2'd3;

  localparam cfg_index_t REG_SCAN_DIVIDER = 3'd0;
  localparam cfg_index_t REG_MAX_SCANS = 3'd1;
  localparam cfg_index_t REG_FLOOR_TICKS = 3'd2;
  localparam cfg_index_t REG_CEILING_TICKS = 3'd3;
  localparam cfg_index_t REG_ADAPTIVE_ENABLE = 3'd4;

  localparam logic [7:0] SCAN_DIVIDER_RESET = 8'd2;
  localparam logic [7:0] MAX_SCANS_RESET = 8'd2;
  localparam logic [31:0] FLOOR_TICKS_RESET = 32'd80000;
  localparam logic [31:0] CEILING_TICKS_RESET = 32'd320000;
  localparam logic ADAPTIVE_ENABLE_RESET = 1'b1;

endpackage

`default_nettype wire

@@ sv/arsp_channels.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface arsp_req_if;
  logic valid;
  logic ready;
  logic [1:0] kind;
  logic [31:0] scan_cost;

  modport source(output valid, output kind, output scan_cost, input ready);
  modport sink(input valid, input kind, input scan_cost, output ready);
endinterface

interface arsp_rsp_if;
  logic valid;
  logic ready;
  logic [7:0] granted_scans;
  logic [31:0] interval_ticks;
  logic [7:0] pending_count;

  modport source(output valid, output granted_scans, output interval_ticks,
                 output pending_count, input ready);
  modport sink(input valid, input granted_scans, input interval_ticks,
               input pending_count, output ready);
endinterface

interface arsp_cfg_if;
  logic valid;
  logic ready;
  logic [2:0] index;
  logic [31:0] data;

  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ sv/adaptive_refresh_scan_pacer_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// A result is presented in the cycle after its request transaction.
// Throughput: one request per cycle; the output register is refilled in the
// same cycle that its result is taken, so only a stalled response holds it.
// Reset (synchronous, active high) clears the response valid, the divider and
// pending count, loads the interval with 80000 and the registers with defaults.

`include "adaptive_refresh_scan_pacer_core_defines.svh"

module adaptive_refresh_scan_pacer_core
  import arsp_pkg::*;
#(
  parameter int unsigned PENDING_LIMIT = 255
) (
  input wire logic clk,
  input wire logic rst,
  arsp_req_if.sink req,
  arsp_rsp_if.source rsp,
  arsp_cfg_if.sink cfg
);

  localparam logic [7:0] PendLimit = PENDING_LIMIT[7:0];

  logic [7:0] scan_divider;
  logic [7:0] max_scans;
  logic [31:0] floor_ticks;
  logic [31:0] ceiling_ticks;
  logic adaptive_enable;

  logic [7:0] tick_divider;
  logic [7:0] pending_scans;
  logic [31:0] refresh_interval;

  logic [7:0] tick_divider_next;
  logic [7:0] pending_scans_next;
  logic [31:0] refresh_interval_next;
  logic [7:0] grant_next;

  logic rsp_valid;
  logic [7:0] granted_scans;
  logic [31:0] interval_ticks;
  logic [7:0] pending_count;

  logic accept;
  logic [7:0] div_inc;
  logic [7:0] grant_min;
  logic [31:0] ease_diff;
  logic [31:0] ease_delta;
  logic [33:0] target_raw;
  logic [33:0] target_lo;
  logic [33:0] target;
  logic [33:0] mixed;

  assign cfg.ready = 1'b1;
  assign req.ready = !rsp_valid || rsp.ready;
  assign accept = req.valid && req.ready;

  assign rsp.valid = rsp_valid;
  assign rsp.granted_scans = granted_scans;
  assign rsp.interval_ticks = interval_ticks;
  assign rsp.pending_count = pending_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_divider <= SCAN_DIVIDER_RESET;
      max_scans <= MAX_SCANS_RESET;
      floor_ticks <= FLOOR_TICKS_RESET;
      ceiling_ticks <= CEILING_TICKS_RESET;
      adaptive_enable <= ADAPTIVE_ENABLE_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_SCAN_DIVIDER: scan_divider <= cfg.data[7:0];
        REG_MAX_SCANS: max_scans <= cfg.data[7:0];
        REG_FLOOR_TICKS: floor_ticks <= cfg.data;
        REG_CEILING_TICKS: ceiling_ticks <= cfg.data;
        REG_ADAPTIVE_ENABLE: adaptive_enable <= cfg.data[0];
        default: ;
      endcase
    end
  end

  assign div_inc = tick_divider + 8'd1;
  assign grant_min = (pending_scans > max_scans) ? max_scans : pending_scans;
  assign ease_diff = refresh_interval - floor_ticks;
  assign ease_delta = (ease_diff[31:3] == 29'd0) ? 32'd1 : {3'd0, ease_diff[31:3]};
  assign target_raw = {2'd0, req.scan_cost} + {4'd0, req.scan_cost[31:2]};
  assign target_lo = (target_raw < {2'd0, floor_ticks}) ? {2'd0, floor_ticks} : target_raw;
  assign target = (target_lo > {2'd0, ceiling_ticks}) ? {2'd0, ceiling_ticks} : target_lo;
  assign mixed = {1'b0, refresh_interval, 1'b0} + {2'd0, refresh_interval} + target;

  always_comb begin
    tick_divider_next = tick_divider;
    pending_scans_next = pending_scans;
    refresh_interval_next = refresh_interval;
    grant_next = 8'd0;
    unique case (req.kind)
      KIND_TICK: begin
        tick_divider_next = div_inc;
        if (div_inc >= scan_divider) begin
          tick_divider_next = 8'd0;
          if (pending_scans < PendLimit) begin
            pending_scans_next = pending_scans + 8'd1;
          end
        end
      end
      KIND_SERVICE: begin
        grant_next = grant_min;
        pending_scans_next = pending_scans - grant_min;
        if (grant_min == 8'd0 && adaptive_enable && refresh_interval > floor_ticks) begin
          refresh_interval_next = refresh_interval - ease_delta;
        end
      end
      KIND_SCAN_DONE: begin
        if (adaptive_enable) begin
          refresh_interval_next = mixed[33:2];
        end else begin
          refresh_interval_next = floor_ticks;
        end
      end
      KIND_RESTART: begin
        tick_divider_next = 8'd0;
        pending_scans_next = 8'd0;
        refresh_interval_next = floor_ticks;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_divider <= 8'd0;
      pending_scans <= 8'd0;
      refresh_interval <= FLOOR_TICKS_RESET;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        tick_divider <= tick_divider_next;
        pending_scans <= pending_scans_next;
        refresh_interval <= refresh_interval_next;
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      granted_scans <= grant_next;
      interval_ticks <= refresh_interval_next;
      pending_count <= pending_scans_next;
    end
  end

  `ARSP_ASSERT_NEXT(a_accept_gives_result, accept, rsp_valid)
  `ARSP_ASSERT_NEXT(a_restart_clears, accept && req.kind == KIND_RESTART,
                    pending_scans == 8'd0 && tick_divider == 8'd0)
  `ARSP_ASSERT_NOW(a_pending_bound, 1'b1, pending_scans <= PendLimit)

endmodule

`default_nettype wire
